@@ design/fbpa_pkg.sv @@
// Package for the fixed-size block pool allocator.
// Holds command and status codes, register indexes and field widths.
// No dependencies.
`default_nettype none

package fbpa_pkg;

  localparam int unsigned IdxW    = 8;
  localparam int unsigned OffW    = 20;
  localparam int unsigned CountW  = 9;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OutW    = 40;

  localparam logic [SizeW-1:0] MaxBlockSize   = 13'd4096;
  localparam logic [SizeW-1:0] ResetBlockSize = 13'd64;
  localparam logic [CountW-1:0] ResetNumBlocks = 9'd8;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOCK_SIZE = 1'b0,
    REG_NUM_BLOCKS = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

@@ design/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator with a LIFO free list.
// Depends on fbpa_pkg and fbpa_ram.
//
// Input stream: tuser carries the command (0 allocate, 1 free), tdata the
// block index to free. Output stream: one result word per input word with
// granted index, byte offset, status and free count.
// An accepted word sits in an input register and is then resolved into
// the output register when the receiver is ready. After every resolved
// word, and after every reinitialisation, the block pauses while the link
// RAM read of the new list head settles, so words are never resolved back
// to back; the registered read port of the link RAM makes this pause
// necessary.
// When the receiver stalls, the result holds in the output register and
// one more word may wait in the input register; further words back up.
// Reset (or any write of a valid register index) makes every block free:
// blocks go out from the highest index down, freed blocks are reused
// first. Write configuration only while the block is idle.
`default_nettype none

module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [IdxW-1:0]    s_axis_tdata,   // [7:0] block_index
  input  wire logic               s_axis_tuser,   // [0] cmd
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [OutW-1:0]    m_axis_tdata,   // [7:0] granted_index,
                                                  // [27:8] byte_offset,
                                                  // [29:28] status,
                                                  // [38:30] free_count
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_addr_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned Depth = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int unsigned Aw    = $clog2(Depth);
  localparam logic [CountW-1:0] CountCap = CountW'(Depth);

  logic [SizeW-1:0]  block_size_q, block_size_d;
  logic [CountW-1:0] num_blocks_q, num_blocks_d;
  logic [Aw-1:0]     head_q, head_d;
  logic [CountW-1:0] untouched_q, untouched_d;
  logic [CountW-1:0] free_q, free_d;
  logic [Depth-1:0]  in_use_q, in_use_d;
  logic              settle_q;

  logic              in_full_q;
  cmd_e              cmd_q;
  logic [IdxW-1:0]   idx_q;

  logic              out_valid_q;
  logic [OutW-1:0]   out_data_q, out_data_d;

  logic              proc;
  logic              reinit;
  logic [CountW-1:0] eff_count;
  logic [CountW-1:0] eff_count_new;
  logic [SizeW-1:0]  eff_size;
  logic [Aw-1:0]     link_rdata;
  logic              link_we;
  logic [Aw-1:0]     idx_low;
  logic [IdxW-1:0]   gi;
  logic              got;
  status_e           status;
  logic [IdxW+SizeW-1:0] product;

  assign proc = in_full_q & ~settle_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_full_q | proc;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign eff_count     = (num_blocks_q > CountCap) ? CountCap : num_blocks_q;
  assign eff_count_new = (num_blocks_d > CountCap) ? CountCap : num_blocks_d;
  assign eff_size      = (block_size_q > MaxBlockSize) ? MaxBlockSize : block_size_q;
  assign idx_low       = idx_q[Aw-1:0];

  always_comb begin
    block_size_d = block_size_q;
    num_blocks_d = num_blocks_q;
    reinit       = 1'b0;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_BLOCK_SIZE: begin
          block_size_d = cfg_wdata_i;
          reinit       = 1'b1;
        end
        REG_NUM_BLOCKS: begin
          num_blocks_d = cfg_wdata_i[CountW-1:0];
          reinit       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    head_d      = head_q;
    untouched_d = untouched_q;
    free_d      = free_q;
    in_use_d    = in_use_q;
    link_we     = 1'b0;
    gi          = '0;
    got         = 1'b0;
    status      = ST_OK;
    if (reinit) begin
      head_d      = '0;
      untouched_d = eff_count_new;
      free_d      = eff_count_new;
      in_use_d    = '0;
    end else if (proc) begin
      unique case (cmd_q)
        CMD_ALLOC: begin
          priority if (free_q > untouched_q) begin
            gi               = IdxW'(head_q);
            head_d           = link_rdata;
            in_use_d[head_q] = 1'b1;
            free_d           = free_q - 1'b1;
            got              = 1'b1;
          end else if (untouched_q != '0) begin
            untouched_d                 = untouched_q - 1'b1;
            gi                          = untouched_d[IdxW-1:0];
            in_use_d[untouched_d[Aw-1:0]] = 1'b1;
            free_d                      = free_q - 1'b1;
            got                         = 1'b1;
          end else begin
            status = ST_EMPTY;
          end
        end
        CMD_FREE: begin
          priority if ({1'b0, idx_q} >= eff_count) begin
            status = ST_RANGE;
          end else if (!in_use_q[idx_low]) begin
            status = ST_DOUBLE;
          end else begin
            link_we           = 1'b1;
            head_d            = idx_low;
            in_use_d[idx_low] = 1'b0;
            free_d            = free_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign product = {{SizeW{1'b0}}, gi} * {{IdxW{1'b0}}, eff_size};

  always_comb begin
    out_data_d = '0;
    out_data_d[IdxW-1:0]          = got ? gi : '0;
    out_data_d[IdxW+OffW-1:IdxW]  = got ? product[OffW-1:0] : '0;
    out_data_d[IdxW+OffW+1:IdxW+OffW] = status;
    out_data_d[IdxW+OffW+2+CountW-1:IdxW+OffW+2] = free_d;
  end

  fbpa_ram #(
    .WIDTH(Aw),
    .DEPTH(Depth)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(idx_low),
    .wdata_i(head_q),
    .raddr_i(head_q),
    .rdata_o(link_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= ResetBlockSize;
      num_blocks_q <= ResetNumBlocks;
      head_q       <= '0;
      untouched_q  <= (ResetNumBlocks > CountCap) ? CountCap : ResetNumBlocks;
      free_q       <= (ResetNumBlocks > CountCap) ? CountCap : ResetNumBlocks;
      in_use_q     <= '0;
      settle_q     <= 1'b0;
      in_full_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      block_size_q <= block_size_d;
      num_blocks_q <= num_blocks_d;
      head_q       <= head_d;
      untouched_q  <= untouched_d;
      free_q       <= free_d;
      in_use_q     <= in_use_d;
      settle_q     <= proc | reinit;
      if (s_axis_tvalid && s_axis_tready) begin
        in_full_q <= 1'b1;
      end else if (proc) begin
        in_full_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= cmd_e'(s_axis_tuser);
      idx_q <= s_axis_tdata;
    end
    if (proc) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

@@ design/fbpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the free-list link storage. No dependencies.
`default_nettype none

module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
